// ===== hw/rtl/cdp_pkg.sv =====
// shared types, constants and defaults for the complex-by-real dot product
package cdp_pkg;

  localparam int TableDepth   = 256;
  localparam int CoefW        = 32;
  localparam int SampleW      = 32;
  localparam int AccW         = 64;
  localparam int ResultW      = 32;
  localparam int LenW         = 9;
  localparam int PosW         = 8;
  localparam int ApbAddrW     = 3;
  localparam int ApbDataW     = 32;
  localparam int MaxLengthDef = 256;
  localparam int FracBitsDef  = 28;

  localparam logic [LenW-1:0] VectorLengthReset = LenW'(1);

  // register index, taken from the word address
  localparam logic [ApbAddrW-3:0] RegVectorLength = '0;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpSample = 1'b1
  } op_e;

  // control word carried alongside each pipeline stage
  typedef struct packed {
    logic valid;
    logic sample;
    logic last;
  } stage_t;

endpackage

// ===== hw/rtl/cdp_in_if.sv =====
// input channel: coefficient loads and complex samples
interface cdp_in_if;
  logic                                valid;
  logic                                ready;
  cdp_pkg::op_e                        operation;
  logic        [cdp_pkg::PosW-1:0]     coef_index;
  logic signed [cdp_pkg::CoefW-1:0]    coef_value;
  logic signed [cdp_pkg::SampleW-1:0]  sample_real;
  logic signed [cdp_pkg::SampleW-1:0]  sample_imag;

  modport source (
    output valid, operation, coef_index, coef_value, sample_real, sample_imag,
    input  ready
  );

  modport sink (
    input  valid, operation, coef_index, coef_value, sample_real, sample_imag,
    output ready
  );
endinterface

// ===== hw/rtl/cdp_out_if.sv =====
// output channel: complex dot product results
interface cdp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cdp_pkg::ResultW-1:0]  result_real;
  logic signed [cdp_pkg::ResultW-1:0]  result_imag;

  modport source (
    output valid, result_real, result_imag,
    input  ready
  );

  modport sink (
    input  valid, result_real, result_imag,
    output ready
  );
endinterface

// ===== hw/rtl/cdp_ram.sv =====
// generic single-port-write, registered-read ram
module cdp_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cdp_cfg.sv =====
// apb register block holding the vector length
module cdp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdp_pkg::ApbAddrW-1:0] paddr,
  input  logic [cdp_pkg::ApbDataW-1:0] pwdata,
  output logic [cdp_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output logic [cdp_pkg::LenW-1:0]     vector_length_o
);

  logic [cdp_pkg::LenW-1:0] len_q, len_d;
  logic                     sel_len;

  assign sel_len = (paddr[cdp_pkg::ApbAddrW-1:2] == cdp_pkg::RegVectorLength);

  always_comb begin
    len_d = len_q;
    if (psel && penable && pwrite && sel_len) begin
      len_d = pwdata[cdp_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= cdp_pkg::VectorLengthReset;
    end else begin
      len_q <= len_d;
    end
  end

  assign prdata = sel_len ? cdp_pkg::ApbDataW'(len_q) : '0;
  assign pready = 1'b1;
  assign vector_length_o = len_q;

endmodule

// ===== hw/rtl/cdp_front.sv =====
// accept stage: position counter, coefficient table addressing, sample capture
module cdp_front #(
  parameter int MaxLength = cdp_pkg::MaxLengthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               advance_i,
  input  logic [cdp_pkg::LenW-1:0]           vector_length_i,
  cdp_in_if.sink                             in_i,
  output logic                               ram_we_o,
  output logic [cdp_pkg::PosW-1:0]           ram_waddr_o,
  output logic [cdp_pkg::CoefW-1:0]          ram_wdata_o,
  output logic [cdp_pkg::PosW-1:0]           ram_raddr_o,
  output cdp_pkg::stage_t                    s1_o,
  output logic signed [cdp_pkg::SampleW-1:0] xr_o,
  output logic signed [cdp_pkg::SampleW-1:0] xi_o
);

  localparam int CapInt = (MaxLength < cdp_pkg::TableDepth) ? MaxLength : cdp_pkg::TableDepth;
  localparam logic [cdp_pkg::LenW-1:0] CapLen = cdp_pkg::LenW'(CapInt);

  logic [cdp_pkg::PosW-1:0]           pos_q, pos_d;
  logic [cdp_pkg::LenW-1:0]           len_eff;
  logic                               accept, is_sample, last;
  cdp_pkg::stage_t                    s1_q, s1_d;
  logic signed [cdp_pkg::SampleW-1:0] xr_q, xi_q;

  assign accept    = in_i.valid && advance_i;
  assign is_sample = (in_i.operation == cdp_pkg::OpSample);

  // zero counts as one, anything above MaxLength or the table depth saturates at the smaller of the two
  always_comb begin
    len_eff = vector_length_i;
    if (len_eff == '0) begin
      len_eff = cdp_pkg::LenW'(1);
    end
    if (len_eff > CapLen) begin
      len_eff = CapLen;
    end
  end

  assign last = ((cdp_pkg::LenW'(pos_q) + cdp_pkg::LenW'(1)) >= len_eff);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (!is_sample || last) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + cdp_pkg::PosW'(1);
      end
    end
  end

  always_comb begin
    s1_d = s1_q;
    if (advance_i) begin
      s1_d.valid  = accept;
      s1_d.sample = is_sample;
      s1_d.last   = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      s1_q  <= '0;
    end else begin
      pos_q <= pos_d;
      s1_q  <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      xr_q <= in_i.sample_real;
      xi_q <= in_i.sample_imag;
    end
  end

  assign in_i.ready  = advance_i;
  assign ram_we_o    = accept && !is_sample;
  assign ram_waddr_o = in_i.coef_index;
  assign ram_wdata_o = in_i.coef_value;
  assign ram_raddr_o = pos_q;
  assign s1_o        = s1_q;
  assign xr_o        = xr_q;
  assign xi_o        = xi_q;

endmodule

// ===== hw/rtl/cdp_mac.sv =====
// product stage, wrapping accumulators and result register
module cdp_mac #(
  parameter int FracBits = cdp_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cdp_pkg::stage_t                    s1_i,
  input  logic signed [cdp_pkg::CoefW-1:0]   coef_i,
  input  logic signed [cdp_pkg::SampleW-1:0] xr_i,
  input  logic signed [cdp_pkg::SampleW-1:0] xi_i,
  output logic                               advance_o,
  cdp_out_if.source                          out_o
);

  cdp_pkg::stage_t                    s2_q, s2_d;
  logic signed [cdp_pkg::AccW-1:0]    prod_re_q, prod_im_q;
  logic signed [cdp_pkg::AccW-1:0]    acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [cdp_pkg::AccW-1:0]    sum_re, sum_im, shr_re, shr_im;
  logic signed [cdp_pkg::ResultW-1:0] res_re_q, res_im_q;
  logic                               out_valid_q, out_valid_d;
  logic                               advance, fire, taken;

  assign fire  = s2_q.valid && s2_q.sample && s2_q.last;
  assign taken = out_valid_q && out_o.ready;

  // the whole pipe moves unless a new result meets one still waiting
  assign advance = !(fire && out_valid_q && !out_o.ready);

  assign sum_re = acc_re_q + prod_re_q;
  assign sum_im = acc_im_q + prod_im_q;
  assign shr_re = sum_re >>> FracBits;
  assign shr_im = sum_im >>> FracBits;

  always_comb begin
    s2_d        = s2_q;
    acc_re_d    = acc_re_q;
    acc_im_d    = acc_im_q;
    out_valid_d = out_valid_q;
    if (taken) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      s2_d = s1_i;
      if (fire) begin
        out_valid_d = 1'b1;
      end
      if (s2_q.valid) begin
        if (!s2_q.sample || s2_q.last) begin
          acc_re_d = '0;
          acc_im_d = '0;
        end else begin
          acc_re_d = sum_re;
          acc_im_d = sum_im;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q        <= '0;
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s2_q        <= s2_d;
      acc_re_q    <= acc_re_d;
      acc_im_q    <= acc_im_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_re_q <= cdp_pkg::AccW'(coef_i) * cdp_pkg::AccW'(xr_i);
      prod_im_q <= cdp_pkg::AccW'(coef_i) * cdp_pkg::AccW'(xi_i);
      if (fire) begin
        res_re_q <= shr_re[cdp_pkg::ResultW-1:0];
        res_im_q <= shr_im[cdp_pkg::ResultW-1:0];
      end
    end
  end

  assign advance_o         = advance;
  assign out_o.valid       = out_valid_q;
  assign out_o.result_real = res_re_q;
  assign out_o.result_imag = res_im_q;

endmodule

// ===== hw/rtl/complex_real_fixed_dot_product.sv =====
// top level: streaming complex-sample by real-coefficient dot product
// result path: the last sample passes the stage-one, product and result registers before the result is valid
// throughput: one input transfer per cycle, loads and samples alike, stalled only
//   while a newly finished result meets one still waiting at the output register
// reset: asynchronous active-low; accumulators, position and valid flags clear,
//   vector length returns to 1, the coefficient table is left unwritten
module complex_real_fixed_dot_product #(
  parameter int MaxLength = cdp_pkg::MaxLengthDef,
  parameter int FracBits  = cdp_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cdp_in_if.sink                       in_i,
  cdp_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdp_pkg::ApbAddrW-1:0] paddr,
  input  logic [cdp_pkg::ApbDataW-1:0] pwdata,
  output logic [cdp_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  // single pipe-wide enable, driven from the output register state, the stage-two control word and the output ready
  logic                               advance;
  logic [cdp_pkg::LenW-1:0]           vector_length;

  // coefficient table port signals
  logic                               ram_we;
  logic [cdp_pkg::PosW-1:0]           ram_waddr, ram_raddr;
  logic [cdp_pkg::CoefW-1:0]          ram_wdata, ram_rdata;

  // stage one: control word and captured sample, aligned with the table read
  cdp_pkg::stage_t                    s1;
  logic signed [cdp_pkg::SampleW-1:0] xr, xi;

  cdp_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .vector_length_o (vector_length)
  );

  // accept stage: a load writes the table, a sample reads it at the current position;
  // the two never share a cycle, so a read always sees the previous write
  cdp_front #(
    .MaxLength (MaxLength)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .vector_length_i (vector_length),
    .in_i            (in_i),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .s1_o            (s1),
    .xr_o            (xr),
    .xi_o            (xi)
  );

  // read data only updates while the pipe moves, so a stall holds the coefficient
  cdp_ram #(
    .Width (cdp_pkg::CoefW),
    .Depth (cdp_pkg::TableDepth)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (advance),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // two 32x32 products registered, then one 64-bit add per accumulator;
  // a load token travelling down the pipe clears the accumulators in order
  cdp_mac #(
    .FracBits (FracBits)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s1_i      (s1),
    .coef_i    (ram_rdata),
    .xr_i      (xr),
    .xi_i      (xi),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule

// ===== hw/rtl/cdp_checker.sv =====
// port-level checker for the dot product top level, with its bind
module cdp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cdp_pkg::ResultW-1:0]  out_real,
  input logic [cdp_pkg::ResultW-1:0]  out_imag,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [cdp_pkg::ApbAddrW-1:0] paddr,
  input logic [cdp_pkg::ApbDataW-1:0] pwdata,
  input logic [cdp_pkg::ApbDataW-1:0] prdata,
  input logic                         pready
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_real) && $stable(out_imag))
    else $error("result changed while stalled");

  // input is held off only by an untaken result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  // a written length reads back
  a_len_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[cdp_pkg::ApbAddrW-1:2] == '0)
    |=> (paddr[cdp_pkg::ApbAddrW-1:2] != '0) ||
        (prdata[cdp_pkg::LenW-1:0] == $past(pwdata[cdp_pkg::LenW-1:0])))
    else $error("vector length readback mismatch");

endmodule

bind complex_real_fixed_dot_product cdp_checker u_cdp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_real  (out_o.result_real),
  .out_imag  (out_o.result_imag),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
